// ===== hw/rtl/irbsp_pkg.sv =====
// Package for the IR beacon steering PID block: widths, register indexes,
// state encoding and a shared lane control struct. No dependencies.
package irbsp_pkg;

  localparam int AdcBitsDef     = 10;
  localparam int DetThreshDef   = 100;
  localparam int SampW          = 10;
  localparam int NumCh          = 4;
  localparam int AmpW           = 11;
  localparam int NormW          = 32;
  localparam int ErrW           = 21;
  localparam int IntegW         = 48;
  localparam int DivW           = 40;

  typedef enum logic [2:0] {
    REG_CUTOFF   = 3'd0,
    REG_BIAS     = 3'd1,
    REG_CW       = 3'd2,
    REG_OW       = 3'd3,
    REG_GAIN_P   = 3'd4,
    REG_GAIN_D   = 3'd5,
    REG_GAIN_I   = 3'd6,
    REG_MIDPOINT = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMP,
    ST_DEN,
    ST_DIV,
    ST_ERR,
    ST_PID_A,
    ST_PID_B,
    ST_PID_C,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/irbsp_tracker.sv =====
// One lane's window max/min tracker.
// Depends on irbsp_pkg.
module irbsp_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_en,
  input  logic                       clear,
  input  logic [irbsp_pkg::SampW-1:0] sample,
  output logic [irbsp_pkg::AmpW-1:0]  amp
);
  import irbsp_pkg::*;

  localparam int AdcBits = AdcBitsDef;

  logic [AdcBits-1:0] s;
  logic [AdcBits:0]   ch_max, ch_min;

  assign s = AdcBits'(sample);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ch_max <= '0;
      ch_min <= (AdcBits+1)'(1) << AdcBits;
    end else if (sample_en) begin
      if ({1'b0, s} > ch_max) ch_max <= {1'b0, s};
      if ({1'b0, s} < ch_min) ch_min <= {1'b0, s};
    end
  end

  assign amp = (ch_max >= ch_min) ? AmpW'(ch_max - ch_min) : '0;
endmodule

// ===== hw/rtl/irbsp_divider.sv =====
// Restoring divider, one quotient bit per cycle; used by each normalizing lane.
// Depends on irbsp_pkg.
module irbsp_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [irbsp_pkg::DivW-1:0] dividend,
  input  logic [irbsp_pkg::DivW-1:0] divisor,
  output logic [irbsp_pkg::DivW-1:0] quotient,
  output logic                       done
);
  import irbsp_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem, quo, dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   trial;

  assign trial = {rem, quo[DivW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DivW]) begin
        rem <= trial[DivW-1:0];
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= {rem[DivW-2:0], quo[DivW-1]};
        quo <= {quo[DivW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
endmodule

// ===== hw/rtl/irbsp_norm_lane.sv =====
// Normalizing lane: forms numerator and denominator for one channel and
// divides them. Depends on irbsp_pkg, irbsp_divider.
module irbsp_norm_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  irbsp_pkg::lane_ctl_t        ctl,
  input  logic                        is_right,
  input  logic [irbsp_pkg::AmpW-1:0]  amp,
  input  logic [9:0]                  bias,
  input  logic [12:0]                 den,
  output logic [irbsp_pkg::NormW-1:0] norm,
  output logic                        done
);
  import irbsp_pkg::*;

  logic [DivW-1:0] num, dvs, q;
  logic [DivW-1:0] amp_scaled;

  // amp*10000, registered so the second multiply has its own stage
  always_ff @(posedge clk) begin
    amp_scaled <= DivW'(amp) * DivW'(10000);
  end

  always_ff @(posedge clk) begin
    if (ctl.busy) begin
      if (is_right) begin
        num <= amp_scaled * DivW'(bias);
        dvs <= DivW'(den) << 8;
      end else begin
        num <= amp_scaled << 8;
        dvs <= DivW'(den) * DivW'(bias);
      end
    end
  end

  irbsp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.start),
    .dividend (num),
    .divisor  (dvs),
    .quotient (q),
    .done     (done)
  );

  assign norm = NormW'(q);
endmodule

// ===== hw/rtl/irbsp_pid.sv =====
// Merge stage: weighted steering error, integral, PID sum and saturation.
// Depends on irbsp_pkg.
module irbsp_pid (
  input  logic                            clk,
  input  logic                            rst,
  input  irbsp_pkg::state_t               state,
  input  logic [irbsp_pkg::NormW-1:0]     norm_l,
  input  logic [irbsp_pkg::NormW-1:0]     norm_r,
  input  logic [irbsp_pkg::NormW-1:0]     norm_fl,
  input  logic [irbsp_pkg::NormW-1:0]     norm_fr,
  input  logic [3:0]                      cw,
  input  logic [3:0]                      ow,
  input  logic signed [31:0]              gain_p,
  input  logic signed [31:0]              gain_d,
  input  logic signed [31:0]              gain_i,
  input  logic [15:0]                     midpoint,
  input  logic [15:0]                     wms,
  output logic [15:0]                     steering,
  output logic signed [irbsp_pkg::ErrW-1:0] steer_error
);
  import irbsp_pkg::*;

  localparam logic signed [39:0] ErrMax = 40'sd1048575;
  localparam logic signed [39:0] ErrMin = -40'sd1048576;
  localparam logic signed [49:0] IntMax = 50'sd140737488355327;
  localparam logic signed [49:0] IntMin = -50'sd140737488355328;
  localparam logic signed [81:0] ProdLim = 82'sd4611686018427387904;

  logic signed [ErrW-1:0]   err, prev_err;
  logic signed [IntegW-1:0] integ;
  logic signed [39:0]       e_inner, e_outer, e_raw;
  logic signed [49:0]       int_sum;
  logic signed [63:0]       p_term, d_term;
  logic signed [65:0]       i_lo, i_hi;
  logic signed [81:0]       i_full;
  logic signed [63:0]       i_term;
  logic signed [65:0]       sum;
  logic signed [49:0]       q;
  logic signed [50:0]       t;

  assign e_inner = 40'(signed'({1'b0, cw})) *
                   (40'(signed'({1'b0, norm_l})) - 40'(signed'({1'b0, norm_r})));
  assign e_outer = 40'(signed'({1'b0, ow})) *
                   (40'(signed'({1'b0, norm_fl})) - 40'(signed'({1'b0, norm_fr})));
  assign e_raw   = e_inner + e_outer;
  assign int_sum = 50'(integ) + 50'(signed'({1'b0, wms})) * 50'(err);

  // integral product split into 24-bit halves, formed in ST_PID_B and ST_PID_C
  assign i_full = (82'(i_hi) <<< 24) + 82'(i_lo);
  assign i_term = (i_full > ProdLim) ? 64'(ProdLim) :
                  (i_full < -ProdLim) ? 64'(-ProdLim) : 64'(i_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      unique case (state)
        ST_ERR: begin
          if (e_raw > ErrMax)      err <= ErrW'(ErrMax);
          else if (e_raw < ErrMin) err <= ErrW'(ErrMin);
          else                     err <= ErrW'(e_raw);
        end
        ST_PID_A: begin
          p_term <= 64'(gain_p) * 64'(err);
          d_term <= 64'(gain_d) * (64'(err) - 64'(prev_err));
          if (int_sum > IntMax)      integ <= IntegW'(IntMax);
          else if (int_sum < IntMin) integ <= IntegW'(IntMin);
          else                       integ <= IntegW'(int_sum);
          prev_err <= err;
        end
        ST_PID_B: i_lo <= 66'(gain_i) * 66'(signed'({1'b0, integ[23:0]}));
        ST_PID_C: i_hi <= 66'(gain_i) * 66'(signed'(integ[47:24]));
        ST_SUM:   sum <= 66'(p_term) + 66'(d_term) + 66'(i_term);
        default: ;
      endcase
    end
  end

  // floor division by 65536 is an arithmetic shift
  assign q = 50'(sum >>> 16);
  assign t = 51'(signed'({1'b0, midpoint})) + 51'(q);
  assign steering = (t < 0) ? 16'd0 : (t > 51'sd65535) ? 16'hFFFF : t[15:0];
  assign steer_error = err;
endmodule

// ===== hw/rtl/ir_beacon_steering_pid_top.sv =====
// Top level of the IR beacon steering PID block.
// Depends on irbsp_pkg, irbsp_tracker, irbsp_norm_lane, irbsp_pid.
// Usage:
//  Input channel (in_valid/in_ready): one transaction per sample set of the
//  four converters. Items without window_end update the per-channel max/min
//  trackers and produce no result; ready stays high for them whenever no
//  window is being computed.
//  An item with window_end starts the window computation: four normalizing
//  lanes run in parallel, each with a bit-serial 40-step divider, then a
//  merge stage forms the weighted error and the PID drive.
//  The input is not ready while a window is being computed.
//  Output channel (out_valid/out_ready): one transaction per window. The
//  result waits in its output register while the receiver stalls, and the
//  next window's samples are still accepted; a later window end waits
//  until the result has gone.
//  Reset (rst, synchronous): registers take their reset values, trackers
//  clear and the PID history is zeroed.
//  Configuration: cfg_we/cfg_index/cfg_data write one register per cycle.
module ir_beacon_steering_pid_top #(
  parameter int DetThresh   = irbsp_pkg::DetThreshDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  sample_left,
  input  logic [9:0]  sample_right,
  input  logic [9:0]  sample_far_left,
  input  logic [9:0]  sample_far_right,
  input  logic [3:0]  freq_ok_mask,
  input  logic        window_end,
  input  logic [15:0] window_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] steering,
  output logic signed [20:0] steer_error,
  output logic        detected
);
  import irbsp_pkg::*;

  logic [9:0]  cutoff, bias_reg;
  logic [3:0]  cw, ow;
  logic signed [31:0] gain_p, gain_d, gain_i;
  logic [15:0] midpoint;

  state_t state, state_next;
  logic [SampW-1:0] samp [NumCh];
  logic [AmpW-1:0]  amp_raw [NumCh];
  logic [AmpW-1:0]  amp_cut [NumCh];
  logic [NormW-1:0] norm [NumCh];
  logic [NumCh-1:0] lane_done;
  logic [3:0]  mask_q;
  logic [15:0] wms_q;
  logic [12:0] den;
  logic [9:0]  bias_eff;
  logic        det_q;
  lane_ctl_t   lctl, lctl_q;
  logic        accept, trk_en, trk_clear;
  logic        lane_setup, div_kick, div_wait;
  logic [15:0] steer_w;
  logic signed [ErrW-1:0] err_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff   <= 10'd50;
      bias_reg <= 10'd269;
      cw       <= 4'd1;
      ow       <= 4'd5;
      gain_p   <= 32'sd66;
      gain_d   <= '0;
      gain_i   <= '0;
      midpoint <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CUTOFF:   cutoff   <= cfg_data[9:0];
        REG_BIAS:     bias_reg <= cfg_data[9:0];
        REG_CW:       cw       <= cfg_data[3:0];
        REG_OW:       ow       <= cfg_data[3:0];
        REG_GAIN_P:   gain_p   <= cfg_data;
        REG_GAIN_D:   gain_d   <= cfg_data;
        REG_GAIN_I:   gain_i   <= cfg_data;
        REG_MIDPOINT: midpoint <= cfg_data[15:0];
      endcase
    end
  end

  assign samp[0] = sample_left;
  assign samp[1] = sample_right;
  assign samp[2] = sample_far_left;
  assign samp[3] = sample_far_right;

  // a window end needs the output register free
  assign in_ready = (state == ST_IDLE) && !(window_end && out_valid);
  assign accept   = in_valid && in_ready;
  assign trk_en   = accept;
  assign trk_clear = (state == ST_AMP);
  assign bias_eff = (bias_reg == 10'd0) ? 10'd1 : bias_reg;

  for (genvar k = 0; k < NumCh; k++) begin : g_lane
    logic [AmpW-1:0] amp_g;
    irbsp_tracker u_trk (
      .clk       (clk),
      .rst       (rst),
      .sample_en (trk_en),
      .clear     (trk_clear),
      .sample    (samp[k]),
      .amp       (amp_g)
    );
    assign amp_raw[k] = mask_q[k] ? amp_g : '0;
    always_ff @(posedge clk) begin
      if (state == ST_AMP) amp_cut[k] <= (amp_raw[k] < AmpW'(cutoff)) ? '0 : amp_raw[k];
    end
    irbsp_norm_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lctl_q),
      .is_right (k % 2 == 1),
      .amp      (amp_cut[k]),
      .bias     (bias_eff),
      .den      (den),
      .norm     (norm[k]),
      .done     (lane_done[k])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_q <= freq_ok_mask;
      wms_q  <= window_ms;
    end
    if (state == ST_AMP) begin
      det_q <= (amp_raw[0] > AmpW'(DetThresh)) || (amp_raw[1] > AmpW'(DetThresh)) ||
               (amp_raw[2] > AmpW'(DetThresh)) || (amp_raw[3] > AmpW'(DetThresh));
    end
    if (state == ST_DEN) begin
      den <= 13'(amp_cut[0]) + 13'(amp_cut[1]) + 13'(amp_cut[2]) +
             13'(amp_cut[3]) + 13'd100;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ST_DEN computes den; lanes register operands in the next cycle, then start
  always_ff @(posedge clk) begin
    if (rst) lane_setup <= 1'b0;
    else     lane_setup <= (state == ST_DEN);
  end

  always_comb begin
    state_next = state;
    lctl.busy  = 1'b0;
    lctl.start = 1'b0;
    lctl.done  = &lane_done;
    unique case (state)
      ST_IDLE:  if (accept && window_end) state_next = ST_AMP;
      ST_AMP:   state_next = ST_DEN;
      ST_DEN:   state_next = ST_DIV;
      ST_DIV: begin
        lctl.busy  = lane_setup;
        lctl.start = 1'b0;
        // done from the previous window is stale until the dividers restart
        if (lane_setup) state_next = ST_DIV;
        else if (div_wait && lctl.done) state_next = ST_ERR;
      end
      ST_ERR:   state_next = ST_PID_A;
      ST_PID_A: state_next = ST_PID_B;
      ST_PID_B: state_next = ST_PID_C;
      ST_PID_C: state_next = ST_SUM;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // divider start is registered from the operand load, so it follows in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_kick <= 1'b0;
      div_wait <= 1'b0;
    end else begin
      div_kick <= lctl.busy;
      div_wait <= (div_wait || div_kick) && !(state_next == ST_ERR);
    end
  end

  always_comb begin
    lctl_q       = lctl;
    lctl_q.start = div_kick;
  end

  irbsp_pid u_pid (
    .clk         (clk),
    .rst         (rst),
    .state       (state),
    .norm_l      (norm[0]),
    .norm_r      (norm[1]),
    .norm_fl     (norm[2]),
    .norm_fr     (norm[3]),
    .cw          (cw),
    .ow          (ow),
    .gain_p      (gain_p),
    .gain_d      (gain_d),
    .gain_i      (gain_i),
    .midpoint    (midpoint),
    .wms         (wms_q),
    .steering    (steer_w),
    .steer_error (err_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      steering    <= steer_w;
      steer_error <= err_w;
      detected    <= det_q;
    end
  end
endmodule
